>>> rtl/core/rgb_conv3x3_filter_top_macros.svh
// ---------------------------------------------------------------------------
// RGB 3x3 convolution filter - assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled in reset on
// rst_ni. They compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RGB_CONV3X3_FILTER_TOP_MACROS_SVH
`define RGB_CONV3X3_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define RCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge outside reset.
`define RCF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define RCF_ASSERT(lbl, prop, msg)
`define RCF_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/core/rcf_pkg.sv
// ---------------------------------------------------------------------------
// RGB 3x3 convolution filter - shared package
// Register codes, kernel modes, stage structs and the kernel arithmetic
// (weighted sum and normalizing divide) used by the filter core.
// ---------------------------------------------------------------------------
package rcf_pkg;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 13;

  // Register fields
  localparam int ModeW       = 2;
  localparam int ImgWidthW   = 11;
  localparam int ImgHeightW  = 13;
  localparam int RowW        = 13;
  localparam int MaxHeight   = 4096;
  localparam int WidthReset  = 640;
  localparam int HeightReset = 480;

  // Pixel layout: red in the low byte, then green, then blue
  localparam int ChanW    = 8;
  localparam int Channels = 3;
  localparam int PixW     = ChanW * Channels;
  localparam int WinDim   = 3;
  localparam int Taps     = WinDim * WinDim;

  // Signed weighted sum spans -1020..2295
  localparam int SumW = 13;

  // Divide by 9 and by 10 as multiply by a rounded-up reciprocal, exact
  // for every nonnegative sum below 2**14
  localparam int RecipW     = 16;
  localparam int RecipShift = 16;
  localparam logic [RecipW-1:0] Recip9  = 16'd7282;
  localparam logic [RecipW-1:0] Recip10 = 16'd6554;
  localparam int EdgeShift = 3;
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FILTER_MODE  = 8'd0,
    REG_IMAGE_WIDTH  = 8'd1,
    REG_IMAGE_HEIGHT = 8'd2
  } cfg_reg_e;

  typedef enum logic [ModeW-1:0] {
    MODE_BLUR    = 2'd0,
    MODE_SHARPEN = 2'd1,
    MODE_EDGE    = 2'd2,
    MODE_EMBOSS  = 2'd3
  } filter_mode_e;

  typedef logic [ChanW-1:0]         chan_t;
  typedef logic [PixW-1:0]          pix_t;
  typedef logic [Taps-1:0][ChanW-1:0] taps_t;
  typedef logic signed [SumW-1:0]   sum_t;

  // Position facts of the centre pixel, decided when its newest item enters
  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } pos_meta_t;

  // One result beat
  typedef struct packed {
    pix_t data;
    logic last;
  } out_beat_t;

  // Weighted 3x3 sum of one channel; taps are ordered row by row, oldest
  // column first, and already zero where the neighbour lies outside
  function automatic sum_t conv_sum(filter_mode_e mode, taps_t p);
    sum_t v [Taps];
    sum_t acc;
    for (int i = 0; i < Taps; i++) begin
      v[i] = sum_t'({1'b0, p[i]});
    end
    case (mode)
      MODE_BLUR:    acc = v[0] + v[1] + v[2] + v[3] + v[4] + v[5] + v[6] + v[7] + v[8];
      MODE_SHARPEN: acc = (v[4] <<< 2) + v[4] - v[1] - v[3] - v[5] - v[7];
      MODE_EDGE:    acc = v[1] + v[3] + v[5] + v[7] - (v[4] <<< 2);
      MODE_EMBOSS:  acc = v[4] + v[5] + v[7] + (v[8] <<< 1) - (v[0] <<< 1) - v[1] - v[3];
      default:      acc = '0;
    endcase
    return acc;
  endfunction

  // Divide by the kernel norm, truncate toward zero, saturate to 0..255
  function automatic chan_t div_norm(filter_mode_e mode, sum_t s);
    logic [SumW-2:0]        mag;
    logic [RecipW-1:0]      recip;
    logic [SumW-2+RecipW:0] prod;
    logic [SumW-2:0]        q;
    chan_t                  res;
    mag   = s[SumW-2:0];
    recip = (mode == MODE_EMBOSS) ? Recip10 : Recip9;
    prod  = mag * recip;
    if (mode == MODE_EDGE) begin
      q = mag >> EdgeShift;
    end else begin
      q = prod[RecipShift +: (SumW-1)];
    end
    if (s[SumW-1]) begin
      res = '0;
    end else if (q > (SumW-1)'(ChanMax)) begin
      res = ChanMax;
    end else begin
      res = q[ChanW-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rcf_ram.sv
// ---------------------------------------------------------------------------
// RGB 3x3 convolution filter - generic RAM
// One write port and one read port, read data registered. A read and a
// write at the same address in one cycle return the old contents.
// ---------------------------------------------------------------------------
module rcf_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rcf_pos.sv
// ---------------------------------------------------------------------------
// RGB 3x3 convolution filter - configuration and raster position
// Holds the registers, tracks the column and row of the next input beat
// and decides the border masks and result flags of the lagging centre.
// ---------------------------------------------------------------------------
`include "rgb_conv3x3_filter_top_macros.svh"

module rcf_pos
  import rcf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int ColW = $clog2(MAX_WIDTH),
  localparam int EffW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  output logic [ColW-1:0]     col_o,
  output logic                bank_o,
  output pos_meta_t           meta_o,
  output filter_mode_e        mode_o
);

  localparam int CmpW     = (EffW > ImgWidthW) ? EffW : ImgWidthW;
  localparam int WidthRst = (MAX_WIDTH < WidthReset) ? MAX_WIDTH : WidthReset;

  filter_mode_e          mode_q, mode_d;
  logic [EffW-1:0]       eff_w_q, eff_w_d;
  logic [ImgHeightW-1:0] eff_h_q, eff_h_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;
  logic                  cfg_hit;
  logic [ImgWidthW-1:0]  iw;
  logic [ImgHeightW-1:0] ih;
  logic                  c0, cr_neg, cr_ge_h, restart, col_end;
  logic [RowW-1:0]       h_p1, h_p2;

  assign iw = cfg_data_i[ImgWidthW-1:0];
  assign ih = cfg_data_i[ImgHeightW-1:0];

  // Decode register writes, saturating width and height on the way in
  always_comb begin
    mode_d  = mode_q;
    eff_w_d = eff_w_q;
    eff_h_d = eff_h_q;
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FILTER_MODE: begin
          mode_d  = filter_mode_e'(cfg_data_i[ModeW-1:0]);
          cfg_hit = 1'b1;
        end
        REG_IMAGE_WIDTH: begin
          if (iw == '0) begin
            eff_w_d = EffW'(1);
          end else if (CmpW'(iw) > CmpW'(MAX_WIDTH)) begin
            eff_w_d = EffW'(MAX_WIDTH);
          end else begin
            eff_w_d = EffW'(iw);
          end
          cfg_hit = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          if (ih == '0) begin
            eff_h_d = ImgHeightW'(1);
          end else if (ih > ImgHeightW'(MaxHeight)) begin
            eff_h_d = ImgHeightW'(MaxHeight);
          end else begin
            eff_h_d = ih;
          end
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Centre lies one row and one column back, or two rows back at column 0
  assign h_p1    = eff_h_q + RowW'(1);
  assign h_p2    = eff_h_q + RowW'(2);
  assign c0      = (col_q == '0);
  assign cr_neg  = c0 ? (row_q < RowW'(2)) : (row_q == '0);
  assign cr_ge_h = c0 ? (row_q >= h_p2) : (row_q >= h_p1);
  assign restart = meta_o.last || cr_ge_h;
  assign col_end = (EffW'(col_q) + EffW'(1)) >= eff_w_q;

  always_comb begin
    meta_o.emit     = !cr_neg && !cr_ge_h;
    meta_o.last     = c0 && (row_q == h_p1);
    meta_o.top_ok   = c0 ? (row_q >= RowW'(3)) : (row_q >= RowW'(2));
    meta_o.bot_ok   = c0 ? (row_q <= eff_h_q) : (row_q < eff_h_q);
    meta_o.left_ok  = c0 ? (eff_w_q >= EffW'(2)) : (col_q >= ColW'(2));
    meta_o.right_ok = !c0;
  end

  // Advance the raster position; drop it on a frame end or register write
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (restart) begin
        col_d = '0;
        row_d = '0;
      end else if (col_end) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BLUR;
      eff_w_q <= EffW'(WidthRst);
      eff_h_q <= ImgHeightW'(HeightReset);
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      eff_w_q <= eff_w_d;
      eff_h_q <= eff_h_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  assign col_o  = col_q;
  assign bank_o = row_q[0];
  assign mode_o = mode_q;

  `RCF_ASSERT(a_col_in_row, EffW'(col_q) < eff_w_q, "column position beyond row width")
  `RCF_ASSERT(a_row_bound, row_q <= h_p1, "row position ran past the frame end")

endmodule

>>> rtl/core/rcf_conv.sv
// ---------------------------------------------------------------------------
// RGB 3x3 convolution filter - window and kernel datapath
// Takes the line-buffer reads, shifts the 3x3 window, forms the masked
// weighted sums and normalizes them into one result beat.
// ---------------------------------------------------------------------------
`include "rgb_conv3x3_filter_top_macros.svh"

module rcf_conv
  import rcf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         adv_i,
  input  logic         accept_i,
  input  pix_t         pix_i,
  input  pos_meta_t    meta_i,
  input  logic         bank_i,
  input  filter_mode_e mode_i,
  input  pix_t         rd0_i,
  input  pix_t         rd1_i,
  output logic         push_o,
  output out_beat_t    beat_o
);

  // Stage 1: beat waiting for its line-buffer reads
  logic      s1_valid_q;
  pix_t      s1_pix_q;
  pos_meta_t s1_meta_q;
  logic      s1_bank_q;
  // Stage 2: window holding the neighbourhood
  logic      s2_valid_q;
  pos_meta_t s2_meta_q;
  pix_t      win_q [WinDim][WinDim];
  // Stage 3: weighted sums
  logic      s3_valid_q;
  logic      s3_emit_q;
  logic      s3_last_q;
  sum_t      s3_sum_q [Channels];

  pix_t        top_pix, mid_pix;
  logic [2:0]  row_ok, col_ok;
  taps_t       taps [Channels];
  sum_t        sum_d [Channels];

  // Valid bits move only when the pipeline advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (adv_i && accept_i) begin
      s1_pix_q  <= pix_i;
      s1_meta_q <= meta_i;
      s1_bank_q <= bank_i;
    end
  end

  // The bank being overwritten holds the row two above
  assign top_pix = s1_bank_q ? rd1_i : rd0_i;
  assign mid_pix = s1_bank_q ? rd0_i : rd1_i;

  // Shift the window left and load the new column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < WinDim; r++) begin
        for (int c = 0; c < WinDim; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (adv_i && s1_valid_q) begin
      for (int r = 0; r < WinDim; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top_pix;
      win_q[1][2] <= mid_pix;
      win_q[2][2] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_valid_q) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  // Mask neighbours outside the image and sum each channel
  assign row_ok = {s2_meta_q.bot_ok, 1'b1, s2_meta_q.top_ok};
  assign col_ok = {s2_meta_q.right_ok, 1'b1, s2_meta_q.left_ok};

  always_comb begin
    for (int ch = 0; ch < Channels; ch++) begin
      for (int r = 0; r < WinDim; r++) begin
        for (int c = 0; c < WinDim; c++) begin
          taps[ch][r*WinDim + c] = (row_ok[r] && col_ok[c]) ?
                                   win_q[r][c][ch*ChanW +: ChanW] : '0;
        end
      end
      sum_d[ch] = conv_sum(mode_i, taps[ch]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s2_valid_q) begin
      s3_emit_q <= s2_meta_q.emit;
      s3_last_q <= s2_meta_q.last;
      for (int ch = 0; ch < Channels; ch++) begin
        s3_sum_q[ch] <= sum_d[ch];
      end
    end
  end

  // Normalize into the result beat
  always_comb begin
    beat_o.last = s3_last_q;
    for (int ch = 0; ch < Channels; ch++) begin
      beat_o.data[ch*ChanW +: ChanW] = div_norm(mode_i, s3_sum_q[ch]);
    end
  end

  assign push_o = adv_i && s3_valid_q && s3_emit_q;

  `RCF_ASSERT(a_last_emits, (s3_valid_q && s3_last_q) |-> s3_emit_q,
              "frame end flagged on a beat that gives no result")

endmodule

>>> rtl/core/rcf_skid.sv
// ---------------------------------------------------------------------------
// RGB 3x3 convolution filter - output skid buffer
// Two-entry result buffer whose ready is a register, so the datapath keeps
// taking beats while a finished result waits at the output.
// ---------------------------------------------------------------------------
`include "rgb_conv3x3_filter_top_macros.svh"

module rcf_skid
  import rcf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_beat_t beat_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_beat_t out_beat_q;
  out_beat_t skid_beat_q;
  logic      out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Refill the output from the skid entry first, else from the datapath
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || push_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_beat_q <= skid_valid_q ? skid_beat_q : beat_i;
    end else if (push_i) begin
      skid_beat_q <= beat_i;
    end
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `RCF_NEVER(a_no_push_when_full, push_i && skid_valid_q, "result pushed into a full buffer")
  `RCF_NEVER(a_skid_behind_out, skid_valid_q && !out_valid_q, "skid entry held with output empty")

endmodule

>>> rtl/core/rgb_conv3x3_filter_top.sv
// ---------------------------------------------------------------------------
// RGB 3x3 convolution filter - top level
// Streaming box blur, sharpen, edge or emboss filter over RGB888 rasters.
// ---------------------------------------------------------------------------
// The filter takes one pixel beat per clock when not stalled, and gives at
// most one result beat per input beat; that rate is set by the line RAMs,
// both read and one written per accepted beat. A result belongs to
// the pixel image_width+1 beats behind the input, so the first
// image_width+1 beats of a frame give nothing and the frame is drained with
// image_width+1 flush beats (tuser high). Once the beat that completes a
// pixel's neighbourhood is accepted, its result passes the s1, window, sum
// and output registers. Neighbours outside the image count as zero; tlast
// marks the bottom-right pixel, after which the next beat starts a new
// frame. Any register write also restarts the frame and is allowed only
// while the filter is idle. The line buffers need no clearing after reset.
`include "rgb_conv3x3_filter_top_macros.svh"

module rgb_conv3x3_filter_top
  import rcf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Register write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Pixel input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic                s_axis_tuser,   // flush
  // Filtered output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic                m_axis_tlast    // frame_last
);

  localparam int ColW = $clog2(MAX_WIDTH);

  logic         adv;
  logic         accept;
  pix_t         pix;
  logic [ColW-1:0] col;
  logic         bank;
  pos_meta_t    meta;
  filter_mode_e mode;
  pix_t         rd0, rd1;
  logic         push;
  out_beat_t    beat;
  out_beat_t    out_beat;

  // The whole pipeline moves while the skid entry is free
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign pix           = s_axis_tuser ? '0 : s_axis_tdata;
  assign cfg_ready_o   = 1'b1;

  rcf_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .col_o       (col),
    .bank_o      (bank),
    .meta_o      (meta),
    .mode_o      (mode)
  );

  // Line buffers: the bank of the current row parity holds the row two up
  rcf_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_row_ram0 (
    .clk_i   (clk_i),
    .we_i    (accept && !bank),
    .waddr_i (col),
    .wdata_i (pix),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (rd0)
  );

  rcf_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH)
  ) u_row_ram1 (
    .clk_i   (clk_i),
    .we_i    (accept && bank),
    .waddr_i (col),
    .wdata_i (pix),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (rd1)
  );

  rcf_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .accept_i (accept),
    .pix_i    (pix),
    .meta_i   (meta),
    .bank_i   (bank),
    .mode_i   (mode),
    .rd0_i    (rd0),
    .rd1_i    (rd1),
    .push_o   (push),
    .beat_o   (beat)
  );

  rcf_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .beat_i      (beat),
    .ready_o     (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (out_beat)
  );

  assign m_axis_tdata = out_beat.data;
  assign m_axis_tlast = out_beat.last;

endmodule
